### hdl/bwsm_pkg.sv
package bwsm_pkg;

   // default sizing of the matcher
   localparam int WINDOW_BYTES_DEF = 16;
   localparam int WORD_COUNT_DEF   = 13;

   // built-in word table
   localparam int TABLE_WORDS  = 13;
   localparam int MAX_WORD_LEN = 16;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 4;
   localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);

   typedef logic [BYTE_W-1:0]              byte_type;
   typedef logic [INDEX_W-1:0]             index_type;
   typedef logic [LEN_W-1:0]               word_len_type;
   typedef logic [MAX_WORD_LEN*BYTE_W-1:0] word_text_type;

   localparam byte_type UPPER_A     = 8'h41;
   localparam byte_type UPPER_Z     = 8'h5a;
   localparam byte_type CASE_OFFSET = 8'h20;

   // words already folded to lower case, right aligned: the last character
   // of a word sits in bits [7:0], the one before it in [15:8] and so on
   localparam word_text_type WORD_TEXT [TABLE_WORDS] = '{
      128'h6e6f_7272_6b6f_7069_6e67,
      128'h70_6172_6973_6869_6c74_6f6e,
      128'h73_706f_6e67_6562_6f62,
      128'h62_7269_746e_6579_7370_6561_7273,
      128'h7061_7269_7325_3230_6869_6c74_6f6e,
      128'h7370_6f6e_6765_2532_3062_6f62,
      128'h6272_6974_6e65_7925_3230_7370_6561_7273,
      128'h7061_7269_735f_6869_6c74_6f6e,
      128'h7370_6f6e_6765_5f62_6f62,
      128'h6272_6974_6e65_795f_7370_6561_7273,
      128'h7061_7269_732b_6869_6c74_6f6e,
      128'h7370_6f6e_6765_2b62_6f62,
      128'h6272_6974_6e65_792b_7370_6561_7273
   };

   localparam word_len_type WORD_LEN [TABLE_WORDS] = '{
      word_len_type'(10), word_len_type'(11), word_len_type'(9),
      word_len_type'(13), word_len_type'(14), word_len_type'(12),
      word_len_type'(16), word_len_type'(12), word_len_type'(10),
      word_len_type'(14), word_len_type'(12), word_len_type'(10),
      word_len_type'(14)
   };

   // ascii letters compare without case, everything else exactly
   function automatic byte_type fold_case(input byte_type c);
      byte_type r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

### hdl/bwsm_req_if.sv
interface bwsm_req_if import bwsm_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

### hdl/bwsm_rsp_if.sv
interface bwsm_rsp_if import bwsm_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      match_here;
   index_type word_index;
   logic      found;
   logic      end_of_message;

   modport source (output valid, output match_here, output word_index, output found,
                   output end_of_message, input ready);
   modport sink   (input valid, input match_here, input word_index, input found,
                   input end_of_message, output ready);
endinterface

### hdl/blocked_word_stream_matcher.sv
// a word accepted passes the input register, then the compare, then the result register
// throughput: one word per cycle while results drain; the compare of all active table
//   entries against the window and the incoming byte is one register-to-register stage
// reset (synchronous, active high): both register stages empty, byte window all zero,
//   sticky found flag cleared
module blocked_word_stream_matcher import bwsm_pkg::*; #(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int WORD_COUNT   = WORD_COUNT_DEF
) (
   input logic         clock,
   input logic         reset,
   bwsm_req_if.sink    req_ch,
   bwsm_rsp_if.source  rsp_ch
);

   // window keeps the bytes before the current one, entry 0 the newest
   localparam int HIST_LEN     = WINDOW_BYTES - 1;
   // only the built-in table exists, a larger count acts as the table size
   localparam int ACTIVE_WORDS = (WORD_COUNT < TABLE_WORDS) ? WORD_COUNT : TABLE_WORDS;

   // input register
   logic     s1_valid_ff;
   byte_type s1_byte_ff;
   logic     s1_last_ff;

   // result register
   logic      out_valid_ff;
   logic      out_match_ff;
   index_type out_index_ff;
   logic      out_found_ff;
   logic      out_last_ff;

   // message state
   byte_type window_ff [HIST_LEN];
   byte_type window_in [HIST_LEN];
   logic     found_ff;
   logic     found_in;

   logic     advance;
   logic     req_take;

   byte_type                back_folded [MAX_WORD_LEN];
   logic [ACTIVE_WORDS-1:0] word_hit;
   logic                    hit;
   index_type               hit_index;

   // the input stage moves on when the result register is free or being drained,
   // so a new word is taken every cycle unless a waiting result is held back
   assign advance  = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_last_ff <= req_ch.last;
      end
   end

   // bytes lined up by distance back from the current byte, folded once and
   // shared by every word comparator; a position past the window reads as zero
   always_comb begin
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
         if (k == 0) begin
            back_folded[k] = fold_case(s1_byte_ff);
         end else if (k - 1 < HIST_LEN) begin
            back_folded[k] = fold_case(window_ff[k-1]);
         end else begin
            back_folded[k] = '0;
         end
      end
   end

   // one comparator per word, all in parallel; a word ends here when each of
   // its characters matches the byte at the same distance back
   always_comb begin
      for (int w = 0; w < ACTIVE_WORDS; w++) begin
         word_hit[w] = (WORD_LEN[w] != '0) && (int'(WORD_LEN[w]) <= WINDOW_BYTES);
         for (int k = 0; k < MAX_WORD_LEN; k++) begin
            if (k < int'(WORD_LEN[w]) &&
                back_folded[k] != WORD_TEXT[w][k*BYTE_W +: BYTE_W]) begin
               word_hit[w] = 1'b0;
            end
         end
      end
   end

   // lowest matching index wins
   always_comb begin
      hit       = |word_hit;
      hit_index = '0;
      for (int w = ACTIVE_WORDS - 1; w >= 0; w--) begin
         if (word_hit[w]) begin
            hit_index = index_type'(w);
         end
      end
   end

   // sticky flag includes a hit on this byte; last byte reports, then clears
   assign found_in = found_ff || hit;

   always_comb begin
      for (int i = 0; i < HIST_LEN; i++) begin
         if (s1_last_ff) begin
            window_in[i] = '0;
         end else if (i == 0) begin
            window_in[i] = s1_byte_ff;
         end else begin
            window_in[i] = window_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         for (int i = 0; i < HIST_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else if (advance) begin
         found_ff <= found_in && !s1_last_ff;
         window_ff <= window_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_match_ff <= hit;
         out_index_ff <= hit_index;
         out_found_ff <= found_in;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.match_here     = out_match_ff;
   assign rsp_ch.word_index     = out_index_ff;
   assign rsp_ch.found          = out_found_ff;
   assign rsp_ch.end_of_message = out_last_ff;

   // a hit shows up in the next result together with the sticky flag
   a_hit_reported: assert property (@(posedge clock) disable iff (reset)
      (advance && hit) |=> (rsp_ch.valid && rsp_ch.match_here && rsp_ch.found))
      else $error("hit not reported with found set");

   // after the last byte of a message the window and flag start clean
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (!found_ff && window_ff[0] == '0))
      else $error("message state not cleared after last byte");

   // a word taken while the input stage is full must be pushing the old one out
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_valid_ff) |-> advance)
      else $error("input stage overwritten");

   // the result register only gets new contents once the old result is taken
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (advance && out_valid_ff) |-> rsp_ch.ready)
      else $error("pending result dropped");

endmodule

### tb/bwsm_match_checker.sv
module bwsm_match_checker import bwsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bwsm_req_if         req_mon,
   bwsm_rsp_if         rsp_mon,
   output int unsigned error_count,
   output int unsigned pending_count
);

   localparam int HISTORY = WINDOW_BYTES_DEF - 1;

   typedef struct packed {
      logic      match_here;
      index_type word_index;
      logic      found;
      logic      end_of_message;
   } match_result_type;

   byte_type         recent_bytes [HISTORY];
   logic             seen_name;
   string            name_table [TABLE_WORDS];
   match_result_type expected_q [$];

   initial begin
      string given [3];
      string family [3];
      string joiner [4];
      given  = '{"Paris", "Sponge", "Britney"};
      family = '{"Hilton", "Bob", "Spears"};
      joiner = '{"", "%20", "_", "+"};
      error_count   = 0;
      pending_count = 0;
      name_table[0] = "Norrkoping";
      for (int w = 1; w < TABLE_WORDS; w++) begin
         name_table[w] = {given[(w-1)%3], joiner[(w-1)/3], family[(w-1)%3]};
      end
   end

   function automatic byte_type to_lower(input byte_type c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // does the name end at the incoming byte, looking back through the window
   function automatic bit name_ends_at(input string name, input byte_type cur);
      int       len;
      byte_type have;
      len = name.len();
      if (len == 0 || len > WINDOW_BYTES_DEF) begin
         return 1'b0;
      end
      for (int k = 0; k < len; k++) begin
         have = (k == 0) ? cur : recent_bytes[k-1];
         if (to_lower(byte_type'(name[len-1-k])) != to_lower(have)) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic predict_match(input byte_type cur, input logic is_last);
      match_result_type r;
      r = '0;
      for (int w = 0; w < TABLE_WORDS && w < WORD_COUNT_DEF; w++) begin
         if (!r.match_here && name_ends_at(name_table[w], cur)) begin
            r.match_here = 1'b1;
            r.word_index = index_type'(w);
         end
      end
      if (r.match_here) begin
         seen_name = 1'b1;
      end
      r.found          = seen_name;
      r.end_of_message = is_last;
      expected_q.push_back(r);
      if (is_last) begin
         foreach (recent_bytes[i]) recent_bytes[i] = '0;
         seen_name = 1'b0;
      end else begin
         for (int i = HISTORY - 1; i > 0; i--) begin
            recent_bytes[i] = recent_bytes[i-1];
         end
         recent_bytes[0] = cur;
      end
   endtask

   always @(posedge clock) begin
      match_result_type got;
      match_result_type want;
      if (reset) begin
         foreach (recent_bytes[i]) recent_bytes[i] = '0;
         seen_name = 1'b0;
         expected_q.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predict_match(req_mon.data_byte, req_mon.last);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.match_here     = rsp_mon.match_here;
            got.word_index     = rsp_mon.word_index;
            got.found          = rsp_mon.found;
            got.end_of_message = rsp_mon.end_of_message;
            if (expected_q.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $write("%0t: result with nothing pending: ", $time);
                  $display("match=%0b index=%0d found=%0b eom=%0b",
                           got.match_here, got.word_index, got.found,
                           got.end_of_message);
               end
            end else begin
               want = expected_q.pop_front();
               if (got.match_here !== want.match_here || got.word_index !== want.word_index ||
                   got.found !== want.found ||
                   got.end_of_message !== want.end_of_message) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("%0t: expected match=%0b index=%0d found=%0b eom=%0b, ",
                            $time, want.match_here, want.word_index, want.found,
                            want.end_of_message);
                     $display("got match=%0b index=%0d found=%0b eom=%0b",
                              got.match_here, got.word_index, got.found,
                              got.end_of_message);
                  end
               end
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

### tb/blocked_word_stream_matcher_tb.sv
module blocked_word_stream_matcher_tb import bwsm_pkg::*; ();

   logic clock;
   logic reset;

   bwsm_req_if req_ch ();
   bwsm_rsp_if rsp_ch ();

   int unsigned mismatches;
   int unsigned outstanding;

   // shared between sender and receiver
   int unsigned words_sent = 0;
   bit          calm       = 1'b0;   // no idling on either side once set

   // pieces the stimulus builds blocked terms and near misses from
   string given_names [3]  = '{"Paris", "Sponge", "Britney"};
   string family_names [3] = '{"Hilton", "Bob", "Spears"};
   string joiners [6]      = '{"", "%20", "_", "+", "-", "%2"};
   string city_name        = "Norrkoping";

   blocked_word_stream_matcher u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bwsm_match_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (mismatches),
      .pending_count (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake locks up
   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

   // flip the case of letters at random, leave everything else alone
   function automatic byte_type mix_case(input byte_type c);
      if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1) == 1) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   task automatic add_text(ref byte_type msg[$], input string s, input bit scramble);
      for (int i = 0; i < s.len(); i++) begin
         msg.push_back(scramble ? mix_case(byte_type'(s[i])) : byte_type'(s[i]));
      end
   endtask

   // one blocked term, mostly intact, sometimes cut short, corrupted or mispaired
   task automatic add_phrase(ref byte_type msg[$]);
      string text;
      int    n;
      int    start;
      start = msg.size();
      if ($urandom_range(0, 9) == 0) begin
         text = city_name;
      end else begin
         n    = $urandom_range(0, 2);
         text = {given_names[n], joiners[$urandom_range(0, 5)],
                 family_names[($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : n]};
      end
      add_text(msg, text, 1'b1);
      case ($urandom_range(0, 7))
         0: begin
            void'(msg.pop_back());
         end
         1: begin
            msg[start + $urandom_range(0, text.len() - 1)] = byte_type'($urandom_range(0, 255));
         end
         default: ;
      endcase
   endtask

   // noise between terms: raw bytes, letters, and the separator characters
   task automatic add_filler(ref byte_type msg[$], input int count);
      string punct;
      punct = "%20_+";
      repeat (count) begin
         case ($urandom_range(0, 2))
            0: msg.push_back(byte_type'($urandom_range(0, 255)));
            1: msg.push_back(mix_case(byte_type'("a" + $urandom_range(0, 25))));
            default: msg.push_back(byte_type'(punct[$urandom_range(0, 4)]));
         endcase
      end
   endtask

   // one message, last raised on the final word, random gaps before words
   task automatic send_message(input byte_type msg[$], input int idle_pct);
      for (int i = 0; i < msg.size(); i++) begin
         if (!calm && $urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.data_byte <= msg[i];
         req_ch.last      <= (i == msg.size() - 1);
         @(posedge clock);
         while (req_ch.ready !== 1'b1) @(posedge clock);
         words_sent++;
         // last stretch of the run goes without idling
         if (words_sent >= 850) begin
            calm = 1'b1;
         end
      end
   endtask

   // receiver: random ready bursts, plus one long hold-off to back the block up
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      repeat (5) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else if (!long_hold_done && words_sent >= 300) begin
            // sender keeps offering while nothing drains
            rsp_ch.ready <= 1'b0;
            repeat (80) @(posedge clock);
            long_hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // sender: reset, directed messages, random messages, drain, verdict
   initial begin
      byte_type msg [$];
      int       idle_pct;
      int       drain;
      int       pick;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last      <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // longest term fills the whole window, odd case, match on the last word
      msg.delete();
      add_text(msg, "bRITNEY%20sPEARS", 1'b0);
      send_message(msg, 30);
      // term split across a message boundary must not match
      msg.delete();
      add_text(msg, "SpongeBo", 1'b0);
      send_message(msg, 30);
      // zero byte and all-ones byte inside a message
      msg.delete();
      add_text(msg, "b", 1'b0);
      msg.push_back(8'h00);
      msg.push_back(8'hff);
      send_message(msg, 30);

      // random messages, mostly built around blocked terms
      while (words_sent < 1000) begin
         msg.delete();
         if ($urandom_range(0, 9) == 0) begin
            add_filler(msg, $urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 9) < 7) begin
                  add_phrase(msg);
               end else begin
                  add_filler(msg, $urandom_range(0, 6));
               end
            end
         end
         if (msg.size() == 0) begin
            msg.push_back(byte_type'($urandom_range(0, 255)));
         end
         // some messages flow back to back, others are gappy
         pick = $urandom_range(0, 3);
         idle_pct = (pick < 2) ? 0 : ((pick == 2) ? 15 : 40);
         send_message(msg, idle_pct);
      end
      req_ch.valid <= 1'b0;
      req_ch.last  <= 1'b0;

      // wait for the pipeline to drain, then wait on for any strays
      drain = 0;
      while (outstanding != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/bwsm_pkg.sv
hdl/bwsm_req_if.sv
hdl/bwsm_rsp_if.sv
hdl/blocked_word_stream_matcher.sv
tb/bwsm_match_checker.sv
tb/blocked_word_stream_matcher_tb.sv
